### rtl/box_blur_3x3_rgb_macros.svh
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb assertion macros
// Shared concurrent assertion forms for the blur block's checkers.
// ----------------------------------------------------------------------------
`ifndef BOX_BLUR_3X3_RGB_MACROS_SVH
`define BOX_BLUR_3X3_RGB_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BB3_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BB3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bb3_pkg.sv
// ----------------------------------------------------------------------------
// bb3_pkg
// Types, constants and helper functions of the 3x3 RGB box blur.
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int CH_W           = 8;          // bits per color channel
  localparam int NUM_CH         = 3;          // blue, green, red
  localparam int PIX_W          = CH_W * NUM_CH;
  localparam int KSIZE          = 3;
  localparam int TAPS           = KSIZE * KSIZE;
  localparam int SUM_W          = 12;         // 9 * 255 fits in 12 bits
  localparam int DIV9_RECIP     = 7282;       // ceil(2^16 / 9)
  localparam int DIV9_SHIFT     = 16;
  localparam int PROD_W         = SUM_W + DIV9_SHIFT;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MIN_SIZE       = 7;

  localparam int CFG_W          = 11;         // size register width
  localparam int CFG_AW         = 3;          // byte address, two 32-bit registers
  localparam int APB_DW         = 32;
  localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(480);

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } bb3_reg_t;

  // floor(s / 9) for s <= 9 * 255: multiply by the rounded-up reciprocal
  function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] s);
    logic [PROD_W-1:0] p;
    p = PROD_W'(s) * PROD_W'(DIV9_RECIP);
    return p[DIV9_SHIFT +: CH_W];
  endfunction

endpackage

### rtl/bb3_if.sv
// ----------------------------------------------------------------------------
// bb3_if
// Valid/ready stream interfaces for incoming pixels and blurred results.
// ----------------------------------------------------------------------------
interface bb3_pix_if;
  logic                      valid;
  logic                      ready;
  logic [bb3_pkg::CH_W-1:0]  pixel_blue;
  logic [bb3_pkg::CH_W-1:0]  pixel_green;
  logic [bb3_pkg::CH_W-1:0]  pixel_red;
  logic                      frame_start;

  modport source (output valid, pixel_blue, pixel_green, pixel_red, frame_start,
                  input ready);
  modport sink   (input valid, pixel_blue, pixel_green, pixel_red, frame_start,
                  output ready);
endinterface

interface bb3_res_if;
  logic                      valid;
  logic                      ready;
  logic [bb3_pkg::CH_W-1:0]  out_blue;
  logic [bb3_pkg::CH_W-1:0]  out_green;
  logic [bb3_pkg::CH_W-1:0]  out_red;
  logic                      frame_last;

  modport source (output valid, out_blue, out_green, out_red, frame_last,
                  input ready);
  modport sink   (input valid, out_blue, out_green, out_red, frame_last,
                  output ready);
endinterface

### rtl/bb3_ram.sv
// ----------------------------------------------------------------------------
// bb3_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bb3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read returns the old word when both ports hit one address
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/bb3_cfg.sv
// ----------------------------------------------------------------------------
// bb3_cfg
// APB-style size registers; presents saturated frame width and height.
// ----------------------------------------------------------------------------
module bb3_cfg #(
  parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bb3_pkg::CFG_AW-1:0]         paddr,
  input  logic [bb3_pkg::APB_DW-1:0]         pwdata,
  output logic [bb3_pkg::APB_DW-1:0]         prdata,
  output logic                               pready,
  output logic [$clog2(MAX_WIDTH+1)-1:0]     size_w,
  output logic [$clog2(MAX_HEIGHT+1)-1:0]    size_h
);

  localparam int WSW = $clog2(MAX_WIDTH + 1);
  localparam int HSW = $clog2(MAX_HEIGHT + 1);

  logic [bb3_pkg::CFG_W-1:0] width_r;
  logic [bb3_pkg::CFG_W-1:0] height_r;
  logic                      wr_en;
  bb3_pkg::bb3_reg_t         reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = bb3_pkg::bb3_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bb3_pkg::WIDTH_RST;
      height_r <= bb3_pkg::HEIGHT_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        bb3_pkg::REG_FRAME_WIDTH:  width_r  <= pwdata[bb3_pkg::CFG_W-1:0];
        bb3_pkg::REG_FRAME_HEIGHT: height_r <= pwdata[bb3_pkg::CFG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      bb3_pkg::REG_FRAME_WIDTH:  prdata = bb3_pkg::APB_DW'(width_r);
      bb3_pkg::REG_FRAME_HEIGHT: prdata = bb3_pkg::APB_DW'(height_r);
    endcase
  end

  // Saturate to [MIN_SIZE, MAX]
  always_comb begin
    if (32'(width_r) < bb3_pkg::MIN_SIZE) begin
      size_w = WSW'(bb3_pkg::MIN_SIZE);
    end else if (32'(width_r) > MAX_WIDTH) begin
      size_w = WSW'(MAX_WIDTH);
    end else begin
      size_w = WSW'(width_r);
    end
    if (32'(height_r) < bb3_pkg::MIN_SIZE) begin
      size_h = HSW'(bb3_pkg::MIN_SIZE);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      size_h = HSW'(MAX_HEIGHT);
    end else begin
      size_h = HSW'(height_r);
    end
  end

endmodule

### rtl/bb3_lane.sv
// ----------------------------------------------------------------------------
// bb3_lane
// One color channel: sum of the nine window taps.
// ----------------------------------------------------------------------------
module bb3_lane (
  input  logic [bb3_pkg::CH_W-1:0]  taps [bb3_pkg::TAPS],
  output logic [bb3_pkg::SUM_W-1:0] sum
);

  always_comb begin
    sum = '0;
    for (int m = 0; m < bb3_pkg::TAPS; m++) begin
      sum = sum + bb3_pkg::SUM_W'(taps[m]);
    end
  end

endmodule

### rtl/box_blur_3x3_rgb.sv
// Path from an accepted pixel to the result it completes on out_ch: stage 1, stage 2, output register.
// Throughput: one pixel per clock while out_ch is not stalled; bounded by the line-store RAM,
//   which takes one read and one write per cycle.
// Reset (rst_n low, synchronous): clears position, window, pipeline valids,
//   and sets the size registers to 640 x 480. Line stores are not cleared.
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb
// 3x3 box blur over a raster stream of 8-bit RGB pixels. Two previous rows
// live in one line-store RAM, two previous columns in a window register set.
// Pixel (r-2, c-2) is emitted when pixel (r, c) arrives.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH  = bb3_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bb3_pkg::MAX_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  bb3_pix_if.sink                     in_ch,
  bb3_res_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bb3_pkg::CFG_AW-1:0]  paddr,
  input  logic [bb3_pkg::APB_DW-1:0]  pwdata,
  output logic [bb3_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int WSW    = $clog2(MAX_WIDTH + 1);
  localparam int HSW    = $clog2(MAX_HEIGHT + 1);
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int PIX_W  = bb3_pkg::PIX_W;
  localparam int CH_W   = bb3_pkg::CH_W;
  localparam int NUM_CH = bb3_pkg::NUM_CH;
  localparam int TAPS   = bb3_pkg::TAPS;
  localparam int LS_W   = 2 * PIX_W;                 // {row r-1, row r-2}
  localparam int EMIT_MIN   = bb3_pkg::KSIZE - 1;    // first emitting row/col
  localparam int INSIDE_MIN = 2 * bb3_pkg::KSIZE - 1;

  // --------------------------------------------------------------------------
  // Size registers
  // --------------------------------------------------------------------------
  logic [WSW-1:0] size_w;
  logic [HSW-1:0] size_h;

  bb3_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .size_w  (size_w),
    .size_h  (size_h)
  );

  // --------------------------------------------------------------------------
  // Pipeline handshake. Stage 1 holds the accepted pixel while the line-store
  // read lands, stage 2 holds the lane sums, stage 3 is the output register.
  // --------------------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic s1_emit_r;
  logic s3_free, s2_free, s1_adv, s2_load, s3_load, in_acc;

  assign s3_free     = !out_valid_r || out_ch.ready;
  assign s2_free     = !s2_valid_r || s3_free;
  assign s1_adv      = s1_valid_r && (!s1_emit_r || s2_free);
  assign s2_load     = s1_valid_r && s1_emit_r && s2_free;
  assign s3_load     = s2_valid_r && s3_free;
  // Take a new transaction whenever stage 1 is empty or empties in the same cycle
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;

  // --------------------------------------------------------------------------
  // Position of the incoming pixel
  // --------------------------------------------------------------------------
  logic [CW-1:0] col_r, col_nxt, c0;
  logic [RW-1:0] row_r, row_nxt, r0;
  logic          wrap_c;
  logic          emit0, inside0, last0;

  always_comb begin
    // Frame start forces (0,0); a count left beyond a shrunk size wraps too
    c0 = (in_ch.frame_start || (32'(col_r) >= 32'(size_w))) ? '0 : col_r;
    r0 = (in_ch.frame_start || (32'(row_r) >= 32'(size_h))) ? '0 : row_r;
    wrap_c = (32'(c0) + 32'd1) >= 32'(size_w);
    if (wrap_c) begin
      col_nxt = '0;
      row_nxt = ((32'(r0) + 32'd1) >= 32'(size_h)) ? '0 : RW'(32'(r0) + 32'd1);
    end else begin
      col_nxt = CW'(32'(c0) + 32'd1);
      row_nxt = r0;
    end
    // Emitted pixel is (r0-2, c0-2); blur applies where it lies at least
    // three pixels in from every edge
    emit0   = (32'(r0) >= EMIT_MIN) && (32'(c0) >= EMIT_MIN);
    inside0 = (32'(r0) >= INSIDE_MIN) && (32'(c0) >= INSIDE_MIN) &&
              ((32'(r0) + 32'd1) < 32'(size_h)) && ((32'(c0) + 32'd1) < 32'(size_w));
    last0   = (32'(r0) == (32'(size_h) - 32'd1)) && (32'(c0) == (32'(size_w) - 32'd1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Line store: word at column c holds {row r-1, row r-2}. Read on accept,
  // write back {new pixel, old row r-1} in the cycle after.
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] s1_px_r;
  logic [CW-1:0]    s1_col_r;
  logic             s1_inside_r, s1_last_r;
  logic             s1_wpend_r;
  logic             s1_fwd_r;
  logic [LS_W-1:0]  s1_fwd_d_r;
  logic [LS_W-1:0]  ls_rdata, ls_wdata;
  logic [PIX_W-1:0] line_a, line_b;

  assign line_a   = s1_fwd_r ? s1_fwd_d_r[LS_W-1:PIX_W] : ls_rdata[LS_W-1:PIX_W];
  assign line_b   = s1_fwd_r ? s1_fwd_d_r[PIX_W-1:0]    : ls_rdata[PIX_W-1:0];
  assign ls_wdata = {s1_px_r, line_a};

  bb3_ram #(
    .WIDTH (LS_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_wpend_r),
    .waddr (s1_col_r),
    .wdata (ls_wdata),
    .re    (in_acc),
    .raddr (c0),
    .rdata (ls_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_wpend_r <= 1'b0;
    end else begin
      s1_wpend_r <= in_acc;
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r     <= {in_ch.pixel_red, in_ch.pixel_green, in_ch.pixel_blue};
      s1_col_r    <= c0;
      s1_emit_r   <= emit0;
      s1_inside_r <= inside0;
      s1_last_r   <= last0;
      // Bypass the write-back landing on the same column in this cycle
      s1_fwd_r    <= s1_wpend_r && (s1_col_r == c0);
      s1_fwd_d_r  <= ls_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Window: columns c-2 and c-1, rows r-2..r. Shift on every stage-1 advance.
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] wc_r [6];
  logic [PIX_W-1:0] win  [TAPS];

  always_comb begin
    win[0] = wc_r[0];  win[1] = wc_r[3];  win[2] = line_b;
    win[3] = wc_r[1];  win[4] = wc_r[4];  win[5] = line_a;
    win[6] = wc_r[2];  win[7] = wc_r[5];  win[8] = s1_px_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) begin
        wc_r[i] <= '0;
      end
    end else if (s1_adv) begin
      wc_r[0] <= win[1];
      wc_r[1] <= win[4];
      wc_r[2] <= win[7];
      wc_r[3] <= win[2];
      wc_r[4] <= win[5];
      wc_r[5] <= win[8];
    end
  end

  // --------------------------------------------------------------------------
  // Channel lanes: one adder per color over the nine taps
  // --------------------------------------------------------------------------
  logic [CH_W-1:0]          taps [NUM_CH][TAPS];
  logic [bb3_pkg::SUM_W-1:0] lane_sum [NUM_CH];

  for (genvar k = 0; k < NUM_CH; k++) begin : g_lane
    always_comb begin
      for (int m = 0; m < TAPS; m++) begin
        taps[k][m] = win[m][k*CH_W +: CH_W];
      end
    end

    bb3_lane u_lane (
      .taps (taps[k]),
      .sum  (lane_sum[k])
    );
  end

  // --------------------------------------------------------------------------
  // Stage 2: lane sums plus the unfiltered top-left pixel
  // --------------------------------------------------------------------------
  logic [bb3_pkg::SUM_W-1:0] s2_sum_r [NUM_CH];
  logic [PIX_W-1:0]          s2_pass_r;
  logic                      s2_inside_r, s2_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_load) begin
      s2_valid_r <= 1'b1;
    end else if (s3_load) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_sum_r    <= lane_sum;
      s2_pass_r   <= win[0];
      s2_inside_r <= s1_inside_r;
      s2_last_r   <= s1_last_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: merge the lanes - divide by nine or pass the original through
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] res_px;
  logic [PIX_W-1:0] out_px_r;
  logic             out_last_r;

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      res_px[k*CH_W +: CH_W] = s2_inside_r ? bb3_pkg::div9(s2_sum_r[k])
                                           : s2_pass_r[k*CH_W +: CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s3_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      out_px_r   <= res_px;
      out_last_r <= s2_last_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_blue   = out_px_r[0*CH_W +: CH_W];
  assign out_ch.out_green  = out_px_r[1*CH_W +: CH_W];
  assign out_ch.out_red    = out_px_r[2*CH_W +: CH_W];
  assign out_ch.frame_last = out_last_r;

endmodule

### rtl/bb3_checker.sv
// ----------------------------------------------------------------------------
// bb3_checker
// Port-level checks of the box blur's result stream and back-pressure.
// ----------------------------------------------------------------------------
`include "box_blur_3x3_rgb_macros.svh"

module bb3_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [bb3_pkg::CH_W-1:0]  out_blue,
  input logic [bb3_pkg::CH_W-1:0]  out_green,
  input logic [bb3_pkg::CH_W-1:0]  out_red,
  input logic                      frame_last
);

  logic out_xfer;
  logic out_stall;

  assign out_xfer  = out_valid && out_ready;
  assign out_stall = out_valid && !out_ready;

  // A stalled result stays offered
  `BB3_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid,
                   "result dropped while stalled")

  // A stalled result keeps its payload
  `BB3_ASSERT_NEXT(a_out_stable, clk, rst_n, out_stall,
                   $stable(out_blue) && $stable(out_green) && $stable(out_red) &&
                   $stable(frame_last), "result payload changed while stalled")

  // With nothing waiting at the output, the whole pipeline drains: input is open
  `BB3_ASSERT_NOW(a_in_open, clk, rst_n, !out_valid, in_ready,
                  "input blocked with empty output")

  // End of frame cannot repeat on back-to-back transactions
  `BB3_ASSERT_NEXT(a_last_once, clk, rst_n, out_xfer && frame_last,
                   !(out_xfer && frame_last), "frame_last on consecutive results")

endmodule

bind box_blur_3x3_rgb bb3_checker u_bb3_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_blue   (out_ch.out_blue),
  .out_green  (out_ch.out_green),
  .out_red    (out_ch.out_red),
  .frame_last (out_ch.frame_last)
);
